### rtl/kmt_pkg.sv
// Shared constants and operation codes for the key membership table.
package kmt_pkg;

  localparam int ENTRIES  = 32;
  localparam int KEY_BITS = 64;

  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int COUNT_W = $clog2(ENTRIES + 1);

  localparam int IN_KEY_W      = 64;
  localparam int OUT_COUNT_W   = 6;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

endpackage

### rtl/kmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/key_membership_table.sv
// Key membership table: sequencer that scans a key RAM with one shared comparator.
//
// Usage:
//   Input channel (in_valid/in_ready, in_op, in_key) takes one operation:
//   lookup, add, remove or clear. Result channel (out_valid/out_ready,
//   out_ok, out_entry_count) returns exactly one result per transaction.
//   The block handles one transaction at a time; in_ready is low while it
//   works. Lookup, add and remove walk the stored entries through the RAM
//   read port, one entry per cycle, with the comparator working on each
//   entry in the cycle after its read is issued. A hit ends the scan early,
//   and a remove that does not hit the last entry moves the last entry
//   into the freed slot. Clear skips the scan. The next transaction is
//   accepted once the result is loaded into the output register.
//   Reset (rst_n low, synchronous) empties the table; RAM contents are not
//   cleared and are never compared until rewritten.
//   A new transaction is accepted while the previous result still waits
//   in the output register; if the receiver stalls, the next result waits
//   in the sequencer until the output register frees up.
module key_membership_table
  import kmt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_op,
  input  logic [IN_KEY_W-1:0]    in_key,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_ok,
  output logic [OUT_COUNT_W-1:0] out_entry_count
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [1:0]           op_r, op_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [COUNT_W-1:0]   idx_r, idx_nxt;
  logic                 pend_r, pend_nxt;
  logic [IDX_W-1:0]     pidx_r, pidx_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     slot_r, slot_nxt;
  logic                 ok_r, ok_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ok_r, out_ok_nxt;
  logic [OUT_COUNT_W-1:0] out_count_r, out_count_nxt;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [KEY_BITS-1:0]  ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [KEY_BITS-1:0]  ram_rdata;
  logic                 hit;
  logic [COUNT_W-1:0]   last;

  kmt_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_entry_count = out_count_r;

  assign hit  = pend_r && (ram_rdata == key_r);
  assign last = count_r - COUNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    pidx_nxt      = pidx_r;
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_count_nxt = out_count_r;
    ram_we        = 1'b0;
    ram_waddr     = slot_r;
    ram_wdata     = key_r;
    ram_raddr     = idx_r[IDX_W-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          key_nxt   = in_key[KEY_BITS-1:0];
          idx_nxt   = '0;
          found_nxt = 1'b0;
          if (in_op == OP_CLEAR) begin
            count_nxt = '0;
            ok_nxt    = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // read of entry idx is issued here, its compare lands next cycle
        if (hit) begin
          found_nxt = 1'b1;
          slot_nxt  = pidx_r;
          state_nxt = ST_RESOLVE;
        end else if (idx_r < count_r) begin
          ram_raddr = idx_r[IDX_W-1:0];
          pend_nxt  = 1'b1;
          pidx_nxt  = idx_r[IDX_W-1:0];
          idx_nxt   = idx_r + COUNT_W'(1);
        end else if (!pend_r) begin
          state_nxt = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        ok_nxt    = 1'b0;
        state_nxt = ST_DONE;
        case (op_r)
          OP_LOOKUP: ok_nxt = found_r;
          OP_ADD: begin
            if (!found_r && (count_r < COUNT_W'(ENTRIES))) begin
              ram_we    = 1'b1;
              ram_waddr = count_r[IDX_W-1:0];
              count_nxt = count_r + COUNT_W'(1);
              ok_nxt    = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (found_r) begin
              ok_nxt = 1'b1;
              if (COUNT_W'(slot_r) != last) begin
                state_nxt = ST_MOVE_RD;
              end else begin
                count_nxt = last;
              end
            end
          end
          default: ok_nxt = 1'b0;
        endcase
      end
      ST_MOVE_RD: begin
        ram_raddr = last[IDX_W-1:0];
        state_nxt = ST_MOVE_WR;
      end
      ST_MOVE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = slot_r;
        ram_wdata = ram_rdata;
        count_nxt = last;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_count_nxt = OUT_COUNT_W'(count_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    idx_r       <= idx_nxt;
    pidx_r      <= pidx_nxt;
    found_r     <= found_nxt;
    slot_r      <= slot_nxt;
    ok_r        <= ok_nxt;
    out_ok_r    <= out_ok_nxt;
    out_count_r <= out_count_nxt;
  end

endmodule

### verif/key_membership_table_checker.sv
// Checker for the key membership table: tracks the table contents and compares every result.
module key_membership_table_checker
  import kmt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [1:0]             in_op,
  input  logic [IN_KEY_W-1:0]    in_key,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   out_ok,
  input  logic [OUT_COUNT_W-1:0] out_entry_count,
  output int                     results_owed,
  output int                     fail_count
);

  typedef struct packed {
    logic                   ok;
    logic [OUT_COUNT_W-1:0] count;
  } table_result_t;

  logic [KEY_BITS-1:0] held_keys [ENTRIES];
  int                  held_count;
  table_result_t       owed_results [$];
  int                  errors;

  function automatic int slot_of(logic [KEY_BITS-1:0] k);
    for (int i = 0; i < held_count; i++) begin
      if (held_keys[i] == k) return i;
    end
    return -1;
  endfunction

  // Applies one operation to the shadow table and returns its result.
  function automatic table_result_t apply_table_op(op_t op, logic [IN_KEY_W-1:0] key);
    logic [KEY_BITS-1:0] k;
    int                  slot;
    table_result_t       r;
    k    = key[KEY_BITS-1:0];
    slot = slot_of(k);
    r.ok = 1'b0;
    case (op)
      OP_LOOKUP: begin
        r.ok = (slot >= 0);
      end
      OP_ADD: begin
        if (slot < 0 && held_count < ENTRIES) begin
          held_keys[held_count] = k;
          held_count++;
          r.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (slot >= 0) begin
          // last entry fills the hole
          held_keys[slot] = held_keys[held_count-1];
          held_count--;
          r.ok = 1'b1;
        end
      end
      default: begin
        held_count = 0;
        r.ok       = 1'b1;
      end
    endcase
    r.count = held_count[OUT_COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    table_result_t got;
    table_result_t want;
    if (!rst_n) begin
      held_count = 0;
      owed_results.delete();
    end else begin
      // compare before pushing so a spurious result never pairs with a new transaction
      if (out_valid && out_ready) begin
        got = '{ok: out_ok, count: out_entry_count};
        if (owed_results.size() == 0) begin
          $display("%0t: result with none expected: ok=%0b entry_count=%0d",
                   $time, got.ok, got.count);
          errors++;
        end else begin
          want = owed_results.pop_front();
          if (got.ok !== want.ok) begin
            $display("%0t: ok mismatch: expected %0b, actual %0b", $time, want.ok, got.ok);
            errors++;
          end
          if (got.count !== want.count) begin
            $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                     $time, want.count, got.count);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        owed_results.push_back(apply_table_op(op_t'(in_op), in_key));
    end
    results_owed <= owed_results.size();
    fail_count   <= errors;
  end

endmodule

### verif/key_membership_table_test.sv
// Top-level test of the key membership table: stimulus, idling, watchdog and verdict.
module key_membership_table_test
  import kmt_pkg::*;
();

  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 40;
  localparam int POOL_SIZE     = 48;
  localparam int SEGMENT_ITEMS = 250;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             in_op = OP_LOOKUP;
  logic [IN_KEY_W-1:0]    in_key = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_ok;
  logic [OUT_COUNT_W-1:0] out_entry_count;

  int results_owed;
  int fail_count;
  int in_idle_pct = 34;
  int out_idle_pct = 34;
  int quiet_cycles = 0;
  logic hold_req = 1'b0;

  logic [IN_KEY_W-1:0] key_pool [POOL_SIZE];

  always #2 clk = ~clk;

  key_membership_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ok          (out_ok),
    .out_entry_count (out_entry_count)
  );

  key_membership_table_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ok          (out_ok),
    .out_entry_count (out_entry_count),
    .results_owed    (results_owed),
    .fail_count      (fail_count)
  );

  // Watchdog: cycles without any transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result receiver; a toggle of hold_req asks for one long hold-off.
  initial begin
    logic hold_seen;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  function automatic logic [IN_KEY_W-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [IN_KEY_W-1:0] pick_key();
    if ($urandom_range(99) < 15) return random_key();
    return key_pool[$urandom_range(POOL_SIZE-1)];
  endfunction

  function automatic op_t pick_op(int w_lookup, int w_add, int w_remove);
    int r;
    r = $urandom_range(99);
    if (r < w_lookup) return OP_LOOKUP;
    if (r < w_lookup + w_add) return OP_ADD;
    if (r < w_lookup + w_add + w_remove) return OP_REMOVE;
    return OP_CLEAR;
  endfunction

  // Offers one transaction and returns at the edge where it is taken.
  task automatic send_op(input op_t op, input logic [IN_KEY_W-1:0] key);
    if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_key   <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic run_segment(int w_lookup, int w_add, int w_remove);
    for (int i = 0; i < SEGMENT_ITEMS; i++)
      send_op(pick_op(w_lookup, w_add, w_remove), pick_key());
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = random_key();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, duplicates, swap-remove, clear
    send_op(OP_LOOKUP, key_pool[0]);
    send_op(OP_REMOVE, key_pool[0]);
    send_op(OP_CLEAR,  key_pool[1]);
    send_op(OP_ADD,    key_pool[0]);
    send_op(OP_ADD,    key_pool[1]);
    send_op(OP_ADD,    key_pool[0]);
    send_op(OP_LOOKUP, key_pool[0]);
    send_op(OP_LOOKUP, key_pool[1]);
    send_op(OP_LOOKUP, key_pool[2]);
    send_op(OP_REMOVE, key_pool[1]);
    send_op(OP_ADD,    key_pool[2]);
    send_op(OP_ADD,    key_pool[3]);
    send_op(OP_ADD,    key_pool[4]);
    send_op(OP_REMOVE, key_pool[0]);
    send_op(OP_LOOKUP, key_pool[4]);
    send_op(OP_LOOKUP, key_pool[0]);
    send_op(OP_REMOVE, key_pool[2]);
    send_op(OP_LOOKUP, key_pool[3]);
    send_op(OP_ADD,    key_pool[1]);
    send_op(OP_REMOVE, key_pool[5]);
    send_op(OP_CLEAR,  key_pool[0]);
    send_op(OP_LOOKUP, key_pool[3]);
    send_op(OP_ADD,    key_pool[3]);
    send_op(OP_LOOKUP, key_pool[3]);
    send_op(OP_REMOVE, key_pool[3]);

    // fill up to a full table
    run_segment(15, 75, 10);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_segment(30, 35, 33);
    in_idle_pct  = 34;
    out_idle_pct = 34;
    // receiver stalls while transactions keep coming
    hold_req <= ~hold_req;
    run_segment(15, 70, 13);
    run_segment(25, 25, 48);
    run_segment(30, 35, 33);
    in_valid <= 1'b0;

    // let the checker count the last transaction before waiting on it
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_owed == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

### key_membership_table.f
rtl/kmt_pkg.sv
rtl/kmt_ram.sv
rtl/key_membership_table.sv
verif/key_membership_table_checker.sv
verif/key_membership_table_test.sv
